### src/scl_pkg.sv
// Shared types, constants and a helper function of the serial command line decoder.
`timescale 1ns / 1ps

package scl_pkg;

    localparam int BUFFER_LEN_DEF = 30;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WEIGHT,
        CMD_FIRST_MEAL,
        CMD_SECOND_MEAL,
        CMD_SHOW_CONFIG
    } scl_cmd_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } scl_phase_t;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Prefix texts, first character in element 0; the padding is never compared.
    localparam logic [0:3][0:15][7:0] PFX_TEXT = '{
        "Peso:           ",
        "Primera Comida: ",
        "Segunda Comida: ",
        "Mostrar Config  "
    };
    localparam logic [0:3][3:0] PFX_LEN = '{4'd5, 4'd15, 4'd15, 4'd14};

    // Magnitude saturation point 2^31, split into hundreds and remainder.
    localparam logic [31:0] MAG_CAP     = 32'h8000_0000;
    localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [24:0] CAP_QUO     = 25'd21474836;
    localparam logic [6:0]  CAP_REM     = 7'd48;
    localparam logic [6:0]  POS_MAX_REM = 7'd47;

    // Number as it stands at the end of a line.
    typedef struct packed {
        logic        negative;
        logic        at_cap;
        logic [31:0] magnitude;
        logic [24:0] quotient;
        logic [6:0]  remainder;
    } scl_num_t;

    // Hundreds digit of a value below 1000.
    function automatic logic [3:0] hundreds(input logic [9:0] v);
        logic [3:0] h;
        h = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 10'(i * 100)) begin
                h = 4'(i);
            end
        end
        return h;
    endfunction

endpackage

### src/scl_scan.sv
// Line scanner: prefix matching and incremental decimal reader.
`timescale 1ns / 1ps

module scl_scan #(
    parameter int BUFFER_LEN = scl_pkg::BUFFER_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        rx_byte,
    output scl_pkg::scl_cmd_t line_cmd,
    output scl_pkg::scl_num_t num
);
    import scl_pkg::*;

    localparam int POS_W = $clog2(BUFFER_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_LEN - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       alive_reg, alive_next;
    scl_phase_t       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic             ended_reg, ended_next;
    logic [31:0]      mag_reg, mag_next;
    logic [24:0]      quo_reg, quo_next;
    logic [6:0]       rem_reg, rem_next;

    logic             is_eol, is_digit, is_ws, is_sign;
    logic [3:0]       past_pfx, hit;
    logic             step, feed;
    logic [3:0]       digit;
    logic [35:0]      mag_ext, mag_prod;
    logic [9:0]       rem_ext, rem_prod, rem_sub;
    logic [3:0]       carry;
    logic [27:0]      quo_ext, quo_prod;
    logic             over;

    assign is_eol   = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_ws    = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                      (rx_byte == CH_VT) || (rx_byte == CH_FF);
    assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            past_pfx[k] = pos_reg >= {{(POS_W - 4){1'b0}}, PFX_LEN[k]};
            hit[k]      = alive_reg[k] && past_pfx[k];
        end
    end

    assign step = take && !is_eol && (pos_reg < POS_LAST);
    assign feed = step && (hit[0] || hit[1] || hit[2]) && !ended_reg &&
                  (phase_reg != PH_DONE);

    // Keep the number as magnitude and also as magnitude/100 and magnitude%100,
    // so that the line end needs no divider.
    assign digit    = 4'(rx_byte - CH_ZERO);
    assign mag_ext  = {4'b0, mag_reg};
    assign mag_prod = (mag_ext << 3) + (mag_ext << 1) + {32'b0, digit};
    assign over     = mag_prod > {4'b0, MAG_CAP};
    assign rem_ext  = {3'b0, rem_reg};
    assign rem_prod = (rem_ext << 3) + (rem_ext << 1) + {6'b0, digit};
    assign carry    = hundreds(rem_prod);
    assign rem_sub  = rem_prod - 10'({6'b0, carry} * 10'd100);
    assign quo_ext  = {3'b0, quo_reg};
    assign quo_prod = (quo_ext << 3) + (quo_ext << 1) + {24'b0, carry};

    always_comb begin
        for (int k = 3; k >= 0; k--) begin
            if (k == 3) begin
                line_cmd = hit[k] ? CMD_SHOW_CONFIG : CMD_NONE;
            end else if (hit[k]) begin
                line_cmd = (k == 0) ? CMD_WEIGHT :
                           (k == 1) ? CMD_FIRST_MEAL : CMD_SECOND_MEAL;
            end
        end
    end

    assign num = '{negative:  neg_reg,
                   at_cap:    mag_reg == MAG_CAP,
                   magnitude: mag_reg,
                   quotient:  quo_reg,
                   remainder: rem_reg};

    // Reader phase.
    always_comb begin
        phase_next = phase_reg;
        if (take && is_eol) begin
            phase_next = PH_SKIP;
        end else if (feed && rx_byte != CH_NUL) begin
            if (is_digit) begin
                phase_next = PH_DIGITS;
            end else if (phase_reg == PH_SKIP && is_ws) begin
                phase_next = PH_SKIP;
            end else if (phase_reg == PH_SKIP && is_sign) begin
                phase_next = PH_SIGN;
            end else begin
                phase_next = PH_DONE;
            end
        end
    end

    // Line position, prefix candidates and number value.
    always_comb begin
        pos_next   = pos_reg;
        alive_next = alive_reg;
        neg_next   = neg_reg;
        ended_next = ended_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (take && is_eol) begin
            pos_next   = '0;
            alive_next = 4'hF;
            neg_next   = 1'b0;
            ended_next = 1'b0;
            mag_next   = '0;
            quo_next   = '0;
            rem_next   = '0;
        end else if (step) begin
            pos_next = pos_reg + 1'b1;
            for (int k = 0; k < 4; k++) begin
                if (!past_pfx[k] && rx_byte != PFX_TEXT[k][pos_reg[3:0]]) begin
                    alive_next[k] = 1'b0;
                end
            end
            if (feed) begin
                if (rx_byte == CH_NUL) begin
                    ended_next = 1'b1;
                end else if (is_digit) begin
                    if (over) begin
                        mag_next = MAG_CAP;
                        quo_next = CAP_QUO;
                        rem_next = CAP_REM;
                    end else begin
                        mag_next = mag_prod[31:0];
                        quo_next = quo_prod[24:0];
                        rem_next = rem_sub[6:0];
                    end
                end else if (phase_reg == PH_SKIP && is_sign) begin
                    neg_next = (rx_byte == CH_MINUS);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            alive_reg <= 4'hF;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            ended_reg <= 1'b0;
            mag_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            alive_reg <= alive_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            ended_reg <= ended_next;
            mag_reg   <= mag_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

### src/scl_store.sv
// Settings store; also the result register of the decoder.
`timescale 1ns / 1ps

module scl_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  scl_pkg::scl_cmd_t   line_cmd,
    input  scl_pkg::scl_num_t   num,
    output scl_pkg::scl_cmd_t   command,
    output logic signed [31:0]  weight_setting,
    output logic signed [25:0]  first_meal_hour,
    output logic signed [7:0]   first_meal_minute,
    output logic signed [25:0]  second_meal_hour,
    output logic signed [7:0]   second_meal_minute
);
    import scl_pkg::*;

    scl_cmd_t           cmd_reg;
    logic signed [31:0] weight_reg, weight_val;
    logic signed [25:0] fh_reg, sh_reg, hour_val;
    logic signed [7:0]  fm_reg, sm_reg, minute_val;

    // Truncation toward zero: the quotient and remainder of a negative number
    // are those of its magnitude, negated.
    always_comb begin
        if (num.negative) begin
            weight_val = -$signed(num.magnitude);
            hour_val   = -$signed({1'b0, num.quotient});
            minute_val = -$signed({1'b0, num.remainder});
        end else begin
            weight_val = num.at_cap ? $signed(POS_MAX) : $signed(num.magnitude);
            hour_val   = $signed({1'b0, num.quotient});
            minute_val = num.at_cap ? $signed({1'b0, POS_MAX_REM})
                                    : $signed({1'b0, num.remainder});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg    <= CMD_NONE;
            weight_reg <= '1;
            fh_reg     <= '1;
            fm_reg     <= '1;
            sh_reg     <= '1;
            sm_reg     <= '1;
        end else if (take) begin
            cmd_reg <= line_cmd;
            unique case (line_cmd)
                CMD_WEIGHT: begin
                    weight_reg <= weight_val;
                end
                CMD_FIRST_MEAL: begin
                    fh_reg <= hour_val;
                    fm_reg <= minute_val;
                end
                CMD_SECOND_MEAL: begin
                    sh_reg <= hour_val;
                    sm_reg <= minute_val;
                end
                default: begin
                end
            endcase
        end
    end

    assign command            = cmd_reg;
    assign weight_setting     = weight_reg;
    assign first_meal_hour    = fh_reg;
    assign first_meal_minute  = fm_reg;
    assign second_meal_hour   = sh_reg;
    assign second_meal_minute = sm_reg;

endmodule

### src/serial_command_line_decoder.sv
// Serial command line decoder: one received byte per word in, one result per line end out.
`timescale 1ns / 1ps

// Takes one received byte per clock cycle while no line end waits. Each byte
// goes into an input register and is scanned from there: prefix compare and one
// decimal digit step, both kept as running values so the line end needs no
// divider. A line feed or carriage return, once consumed, produces one registered
// result word, carrying the command kind and all stored settings.
// Ordinary bytes never wait; a line-end byte waits in the input register only
// while the previous result has not been taken, so the sustained rate is one
// byte per cycle as long as the result side keeps up.
module serial_command_line_decoder #(
    parameter int BUFFER_LEN = scl_pkg::BUFFER_LEN_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] command, [34:3] weight_setting, [60:35] first_meal_hour,
    // [68:61] first_meal_minute, [94:69] second_meal_hour,
    // [102:95] second_meal_minute, [103] zero
    output logic [103:0] m_tdata
);
    import scl_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_eol, out_free, consume, eol_take;

    scl_cmd_t           line_cmd, command;
    scl_num_t           num;
    logic signed [31:0] weight_setting;
    logic signed [25:0] first_meal_hour, second_meal_hour;
    logic signed [7:0]  first_meal_minute, second_meal_minute;

    assign in_eol   = (in_byte_reg == CH_LF) || (in_byte_reg == CH_CR);
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_eol || out_free);
    assign eol_take = consume && in_eol;
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (eol_take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    scl_scan #(
        .BUFFER_LEN(BUFFER_LEN)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (consume),
        .rx_byte (in_byte_reg),
        .line_cmd(line_cmd),
        .num     (num)
    );

    scl_store u_store (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .take              (eol_take),
        .line_cmd          (line_cmd),
        .num               (num),
        .command           (command),
        .weight_setting    (weight_setting),
        .first_meal_hour   (first_meal_hour),
        .first_meal_minute (first_meal_minute),
        .second_meal_hour  (second_meal_hour),
        .second_meal_minute(second_meal_minute)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, second_meal_minute, second_meal_hour, first_meal_minute,
                       first_meal_hour, weight_setting, command};

    // A result word appears only after a line-end byte was consumed.
    a_result_from_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(eol_take))
        else $error("result word without a consumed line end");

    // Bytes other than line ends never stall in the input register.
    a_plain_byte_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_eol) |-> consume)
        else $error("ordinary byte stalled");

    // A waiting line end holds its byte until it can be consumed.
    a_eol_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending line end lost");

    // The settings only change when a line end is consumed.
    a_settings_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !eol_take |=> $stable(m_tdata))
        else $error("settings changed without a line end");

endmodule
